/* rtl/core/mf3_pkg.sv */
// Shared constants, types and compare helpers for the 3x3 median filter.
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int HIST_DEPTH = 2;

  // Reset image size, stored as size minus one.
  localparam logic [COL_W-1:0] WIDTH_M1_RST  = COL_W'(640 - 1);
  localparam logic [ROW_W-1:0] HEIGHT_M1_RST = ROW_W'(480 - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // One sorted three-pixel column.
  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] mn;
  } col_t;

  // Line store entry: both rows above the current pixel.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  // Line store access controls.
  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } ls_ctrl_t;

  // One filtered result.
  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } res_t;

  function automatic logic [PIX_W-1:0] pix_lo(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    pix_lo = (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] pix_hi(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    pix_hi = (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    med3 = pix_hi(pix_lo(a, b), pix_lo(pix_hi(a, b), c));
  endfunction

endpackage

/* rtl/core/mf3_if.sv */
// Channel interfaces: pixel input, filtered result output, configuration write.
interface mf3_pix_if;
  logic                        valid;
  logic                        ready;
  logic [mf3_pkg::PIX_W-1:0]   pixel_value;
  logic                        frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
  modport monitor (input valid, input ready, input pixel_value, input frame_start);
endinterface

interface mf3_res_if;
  logic                        valid;
  logic                        ready;
  logic [mf3_pkg::PIX_W-1:0]   median_value;
  logic [mf3_pkg::ROW_W-1:0]   out_row;
  logic [mf3_pkg::COL_W-1:0]   out_col;
  logic                        last_in_burst;
  logic                        frame_done;

  modport source (output valid, output median_value, output out_row, output out_col,
                  output last_in_burst, output frame_done, input ready);
  modport sink   (input valid, input median_value, input out_row, input out_col,
                  input last_in_burst, input frame_done, output ready);
  modport monitor (input valid, input ready, input median_value, input out_row,
                   input out_col, input last_in_burst, input frame_done);
endinterface

interface mf3_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mf3_pkg::CFG_IDX_W-1:0]   index;
  logic [mf3_pkg::CFG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport monitor (input valid, input ready, input index, input data);
endinterface

/* rtl/core/mf3_line_store.sv */
// Two line stores packed side by side in one memory, registered read.
module mf3_line_store (
  input  logic                  clk,
  input  mf3_pkg::ls_ctrl_t     ctrl,
  input  mf3_pkg::line_pair_t   wr_data,
  output mf3_pkg::line_pair_t   rd_data
);

  mf3_pkg::line_pair_t mem [mf3_pkg::MAX_WIDTH];
  mf3_pkg::line_pair_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= mem[ctrl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/mf3_col_cell.sv */
// One column-history cell: holds a sorted column, loads from its neighbor.
module mf3_col_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  mf3_pkg::col_t  din,
  output mf3_pkg::col_t  q
);

  mf3_pkg::col_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= din;
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/median_filter_3x3_top.sv */
// Top level of the streaming 3x3 median filter.
//
//   channel   dir  fields                                             handshake
//   in_chan   in   pixel_value[15:0] frame_start                      valid/ready
//   out_chan  out  median_value[15:0] out_row[9:0] out_col[9:0]       valid/ready
//                  last_in_burst frame_done
//   cfg_chan  in   index[1:0] data[10:0] (0 width, 1 height)          valid/ready
//
// One pixel is taken per cycle unless the pipeline stalls; a result is offered from the
// output register after stage 1 (line store read and column sort) and stage 2 (history
// and window median). A last-column pixel gives two results that leave one after the
// other from the single output register pair.
// Reset is synchronous; line stores are not cleared and are valid once written.
// A stalled output holds the pipeline; the input stalls only when it is full.
module median_filter_3x3_top (
  input  logic          clk,
  input  logic          rst_n,
  mf3_pix_if.sink       in_chan,
  mf3_res_if.source     out_chan,
  mf3_cfg_if.sink       cfg_chan
);

  localparam int COL_W = mf3_pkg::COL_W;
  localparam int ROW_W = mf3_pkg::ROW_W;
  localparam int PIX_W = mf3_pkg::PIX_W;
  localparam int HD    = mf3_pkg::HIST_DEPTH;

  // ---------------------------------------------------------------- config
  logic [COL_W-1:0] width_m1_r;
  logic [ROW_W-1:0] height_m1_r;
  logic [COL_W-1:0] width_m1_nxt;
  logic [ROW_W-1:0] height_m1_nxt;

  assign cfg_chan.ready = 1'b1;

  // clamp to legal size and keep size minus one
  always_comb begin
    if (cfg_chan.data < mf3_pkg::CFG_W'(2)) begin
      width_m1_nxt = COL_W'(1);
    end else if (cfg_chan.data > mf3_pkg::CFG_W'(mf3_pkg::MAX_WIDTH)) begin
      width_m1_nxt = COL_W'(mf3_pkg::MAX_WIDTH - 1);
    end else begin
      width_m1_nxt = COL_W'(cfg_chan.data - mf3_pkg::CFG_W'(1));
    end
    if (cfg_chan.data < mf3_pkg::CFG_W'(3)) begin
      height_m1_nxt = ROW_W'(2);
    end else if (cfg_chan.data > mf3_pkg::CFG_W'(mf3_pkg::MAX_HEIGHT)) begin
      height_m1_nxt = ROW_W'(mf3_pkg::MAX_HEIGHT - 1);
    end else begin
      height_m1_nxt = ROW_W'(cfg_chan.data - mf3_pkg::CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_m1_r  <= mf3_pkg::WIDTH_M1_RST;
      height_m1_r <= mf3_pkg::HEIGHT_M1_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        mf3_pkg::CFG_IMAGE_WIDTH:  width_m1_r  <= width_m1_nxt;
        mf3_pkg::CFG_IMAGE_HEIGHT: height_m1_r <= height_m1_nxt;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- position
  logic             in_take;
  logic [COL_W-1:0] col_r, col_nxt, c_raw, c_cur;
  logic [ROW_W-1:0] row_r, row_nxt, r_raw, r_cur;
  logic             last_col, last_row;

  assign in_take = in_chan.valid && in_chan.ready;

  always_comb begin
    c_raw    = in_chan.frame_start ? '0 : col_r;
    r_raw    = in_chan.frame_start ? '0 : row_r;
    last_col = (c_raw >= width_m1_r);
    last_row = (r_raw >= height_m1_r);
    c_cur    = last_col ? width_m1_r : c_raw;
    r_cur    = last_row ? height_m1_r : r_raw;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_nxt = c_cur + COL_W'(1);
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------- stage 1: read, sort
  logic                 s1_v_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic                 s1_last_col_r, s1_last_row_r;
  logic                 s1_fwd_r;
  mf3_pkg::line_pair_t  s1_fwd_data_r;
  mf3_pkg::line_pair_t  ls_rd, ls_wr, s1_pair;
  mf3_pkg::ls_ctrl_t    ls_ctrl;
  mf3_pkg::col_t        s1_col_sort;
  logic [PIX_W-1:0]     t1, t2, t3;
  logic                 s1_adv, s2_free, s2_adv;

  assign s1_adv        = s1_v_r && s2_free;
  assign in_chan.ready = !s1_v_r || s2_free;

  // newest line data: forward the write that lands on the same edge as the read
  assign s1_pair      = s1_fwd_r ? s1_fwd_data_r : ls_rd;
  assign ls_wr.upper  = s1_pair.middle;
  assign ls_wr.middle = s1_pix_r;

  assign ls_ctrl.rd_en   = in_take;
  assign ls_ctrl.rd_addr = c_cur;
  assign ls_ctrl.wr_en   = s1_adv;
  assign ls_ctrl.wr_addr = s1_col_r;

  mf3_line_store u_line_store (
    .clk     (clk),
    .ctrl    (ls_ctrl),
    .wr_data (ls_wr),
    .rd_data (ls_rd)
  );

  // three-pixel column sort
  always_comb begin
    t1 = mf3_pkg::pix_lo(s1_pair.middle, s1_pix_r);
    t2 = mf3_pkg::pix_hi(s1_pair.middle, s1_pix_r);
    s1_col_sort.mn = mf3_pkg::pix_lo(s1_pair.upper, t1);
    t3 = mf3_pkg::pix_hi(s1_pair.upper, t1);
    s1_col_sort.md = mf3_pkg::pix_lo(t3, t2);
    s1_col_sort.mx = mf3_pkg::pix_hi(t3, t2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r      <= in_chan.pixel_value;
      s1_col_r      <= c_cur;
      s1_row_r      <= r_cur;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
      s1_fwd_r      <= s1_v_r && (s1_col_r == c_cur);
      s1_fwd_data_r <= ls_wr;
    end
  end

  // ---------------------------------------------- stage 2: history, median
  logic                 s2_v_r;
  mf3_pkg::col_t        s2_col_r;
  logic                 s2_gen_r, s2_edge_r, s2_last_col_r, s2_last_row_r;
  logic [COL_W-1:0]     s2_c_r;
  logic [ROW_W-1:0]     s2_row_r;
  logic                 produce;
  logic                 ob_free;
  mf3_pkg::col_t        hist_q [HD];
  mf3_pkg::res_t        res0, res1;

  assign produce = s2_gen_r && !s2_edge_r;
  assign s2_adv  = s2_v_r && (!produce || ob_free);
  assign s2_free = !s2_v_r || s2_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= 1'b1;
    end else if (s2_adv) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col_r      <= s1_col_sort;
      s2_gen_r      <= (s1_row_r >= ROW_W'(2));
      s2_edge_r     <= (s1_col_r == '0);
      s2_last_col_r <= s1_last_col_r;
      s2_last_row_r <= s1_last_row_r;
      s2_c_r        <= s1_col_r;
      s2_row_r      <= s1_row_r - ROW_W'(1);
    end
  end

  // chain of column cells; at column 0 every cell takes the edge column
  for (genvar i = 0; i < HD; i++) begin : g_hist
    mf3_pkg::col_t din;
    if (i == HD - 1) begin : g_tail
      assign din = s2_col_r;
    end else begin : g_link
      assign din = s2_edge_r ? s2_col_r : hist_q[i+1];
    end
    mf3_col_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (s2_adv && s2_gen_r),
      .din   (din),
      .q     (hist_q[i])
    );
  end

  // window median for the column to the left, and the right-border repeat
  always_comb begin
    res0.median = mf3_pkg::med3(
      mf3_pkg::pix_lo(mf3_pkg::pix_lo(hist_q[0].mx, hist_q[HD-1].mx), s2_col_r.mx),
      mf3_pkg::pix_hi(mf3_pkg::pix_hi(hist_q[0].mn, hist_q[HD-1].mn), s2_col_r.mn),
      mf3_pkg::med3(hist_q[0].md, hist_q[HD-1].md, s2_col_r.md));
    res0.row  = s2_row_r;
    res0.col  = s2_c_r - COL_W'(1);
    res0.last = !s2_last_col_r;
    res0.done = 1'b0;

    res1.median = mf3_pkg::med3(
      mf3_pkg::pix_lo(hist_q[HD-1].mx, s2_col_r.mx),
      mf3_pkg::pix_hi(hist_q[HD-1].mn, s2_col_r.mn),
      s2_col_r.md);
    res1.row  = s2_row_r;
    res1.col  = s2_c_r;
    res1.last = 1'b1;
    res1.done = s2_last_row_r;
  end

  // ------------------------------------------------------ output register
  logic          ob_v_r, ob_two_r, ob_ph_r;
  mf3_pkg::res_t ob_res0_r, ob_res1_r, ob_cur;
  logic          ob_load, out_take;

  assign ob_load  = s2_adv && produce;
  assign out_take = out_chan.valid && out_chan.ready;
  assign ob_free  = !ob_v_r || (out_chan.ready && (!ob_two_r || ob_ph_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_v_r   <= 1'b0;
      ob_two_r <= 1'b0;
      ob_ph_r  <= 1'b0;
    end else if (ob_load) begin
      ob_v_r   <= 1'b1;
      ob_two_r <= s2_last_col_r;
      ob_ph_r  <= 1'b0;
    end else if (out_take) begin
      if (ob_two_r && !ob_ph_r) begin
        ob_ph_r <= 1'b1;
      end else begin
        ob_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) begin
      ob_res0_r <= res0;
      ob_res1_r <= res1;
    end
  end

  assign ob_cur                 = ob_ph_r ? ob_res1_r : ob_res0_r;
  assign out_chan.valid         = ob_v_r;
  assign out_chan.median_value  = ob_cur.median;
  assign out_chan.out_row       = ob_cur.row;
  assign out_chan.out_col       = ob_cur.col;
  assign out_chan.last_in_burst = ob_cur.last;
  assign out_chan.frame_done    = ob_cur.done;

endmodule

/* rtl/core/mf3_checker.sv */
// Port-level checks for the 3x3 median filter, bound to the top level.
module mf3_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mf3_pkg::PIX_W-1:0]   out_median_value,
  input logic [mf3_pkg::ROW_W-1:0]   out_row,
  input logic [mf3_pkg::COL_W-1:0]   out_col,
  input logic                        out_last_in_burst,
  input logic                        out_frame_done,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_median_value) && $stable(out_col))
    else $error("stalled result changed");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // the first of a pair is followed at once by its right neighbor
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_in_burst |=>
      out_valid && out_row == $past(out_row) &&
      out_col == mf3_pkg::COL_W'($past(out_col) + 1'b1))
    else $error("second result of a pair missing or misplaced");

  // frame end only closes a burst
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_in_burst)
    else $error("frame end on a non-final result");

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration request stalled");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_median_value  (out_chan.median_value),
  .out_row           (out_chan.out_row),
  .out_col           (out_chan.out_col),
  .out_last_in_burst (out_chan.last_in_burst),
  .out_frame_done    (out_chan.frame_done),
  .cfg_valid         (cfg_chan.valid),
  .cfg_ready         (cfg_chan.ready)
);

/* verif/tb_median_filter_3x3_top.sv */
// Self-checking testbench for the streaming 3x3 median filter top level.
`timescale 1ns / 1ps

module tb_median_filter_3x3_top;

  localparam int PIX_W      = mf3_pkg::PIX_W;
  localparam int ROW_W      = mf3_pkg::ROW_W;
  localparam int COL_W      = mf3_pkg::COL_W;
  localparam int CFG_W      = mf3_pkg::CFG_W;
  localparam int MAX_WIDTH  = mf3_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT;

  localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin
  localparam int RANDOM_PIXELS = 240;

  logic clk;
  logic rst_n;

  mf3_pix_if pix_ch ();
  mf3_res_if res_ch ();
  mf3_cfg_if cfg_ch ();

  median_filter_3x3_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_ch),
    .out_chan (res_ch),
    .cfg_chan (cfg_ch)
  );

  // Filter shadow: line stores, column history, raster position, size registers
  logic [PIX_W-1:0] up_line  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_line [MAX_WIDTH];
  logic [PIX_W-1:0] hist_max [2];
  logic [PIX_W-1:0] hist_med [2];
  logic [PIX_W-1:0] hist_min [2];
  int               col_pos;
  int               row_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  mf3_pkg::res_t pending_medians[$];
  int            mismatches;
  bit            steady;      // no idle cycles on either side while set

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [PIX_W-1:0] smaller(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] larger(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] mid_of3(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  // Effective sizes after clamping
  function automatic int eff_width(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int eff_height(input logic [CFG_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(v);
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pixel values: extremes, clustered values for ties, and full range
  function automatic logic [PIX_W-1:0] rand_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 45) return PIX_W'(16'h7FFC + $urandom_range(0, 7));
    return PIX_W'($urandom());
  endfunction

  // Predict the medians caused by one accepted pixel
  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int               w, h, r, c;
    bit               at_right, at_bottom;
    logic [PIX_W-1:0] a, b, cmx, cmd, cmn, lo_max, hi_min, mid_med;
    mf3_pkg::res_t    e;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = w - 1;
    if (row_pos >= h) row_pos = h - 1;
    r = row_pos;
    c = col_pos;
    at_right  = (c == w - 1);
    at_bottom = (r == h - 1);
    a = up_line[c];
    b = mid_line[c];

    if (r >= 2) begin
      cmx = larger(larger(a, b), pix);
      cmn = smaller(smaller(a, b), pix);
      cmd = mid_of3(a, b, pix);
      if (c == 0) begin
        // left border: column 0 stands in for the column to its left
        hist_max = '{cmx, cmx};
        hist_med = '{cmd, cmd};
        hist_min = '{cmn, cmn};
      end else begin
        lo_max  = smaller(smaller(hist_max[0], hist_max[1]), cmx);
        hi_min  = larger(larger(hist_min[0], hist_min[1]), cmn);
        mid_med = mid_of3(hist_med[0], hist_med[1], cmd);
        e.median = mid_of3(lo_max, hi_min, mid_med);
        e.row    = ROW_W'(r - 1);
        e.col    = COL_W'(c - 1);
        e.last   = !at_right;
        e.done   = 1'b0;
        pending_medians.push_back(e);
        hist_max = '{hist_max[1], cmx};
        hist_med = '{hist_med[1], cmd};
        hist_min = '{hist_min[1], cmn};
        // right border repeats the last column
        if (at_right) begin
          lo_max   = smaller(hist_max[0], hist_max[1]);
          hi_min   = larger(hist_min[0], hist_min[1]);
          e.median = mid_of3(lo_max, hi_min, hist_med[1]);
          e.row    = ROW_W'(r - 1);
          e.col    = COL_W'(c);
          e.last   = 1'b1;
          e.done   = at_bottom;
          pending_medians.push_back(e);
        end
      end
    end

    up_line[c]  = b;
    mid_line[c] = pix;
    if (at_right) begin
      col_pos = 0;
      row_pos = at_bottom ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Result ready: runs of ready broken by random stalls
  initial begin
    int run;
    int gap;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 24);
      res_ch.ready = 1'b1;
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin : check_result
    mf3_pkg::res_t got;
    mf3_pkg::res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.median = res_ch.median_value;
      got.row    = res_ch.out_row;
      got.col    = res_ch.out_col;
      got.last   = res_ch.last_in_burst;
      got.done   = res_ch.frame_done;
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result median=%h row=%0d col=%0d last=%b done=%b",
                   $realtime, got.median, got.row, got.col, got.last, got.done);
      end else begin
        want = pending_medians.pop_front();
        if (got.median !== want.median || got.row !== want.row || got.col !== want.col ||
            got.last !== want.last || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch exp median=%h row=%0d col=%0d last=%b done=%b",
                     $realtime, want.median, want.row, want.col, want.last, want.done);
            $display("%0t:                 got median=%h row=%0d col=%0d last=%b done=%b",
                     $realtime, got.median, got.row, got.col, got.last, got.done);
          end
        end
      end
    end
  end

  // Send one pixel request; starts and ends on a falling edge with valid low
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) repeat (gap) @(negedge clk);
    pix_ch.pixel_value = pix;
    pix_ch.frame_start = fs;
    pix_ch.valid       = 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    predict_pixel(pix, fs);
    @(negedge clk);
    pix_ch.valid = 1'b0;
  endtask

  // Hold off until every expected result is out and the pipeline is empty
  task automatic wait_drained();
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input mf3_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == mf3_pkg::CFG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(mf3_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // Random pixels; fs_noise is a per-mille rate of stray frame starts
  task automatic send_span(input int count, input bit fs_first, input int fs_noise,
                           input int pause_at);
    bit fs;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) ? fs_first : ($urandom_range(999) < fs_noise);
      if (i == pause_at) wait_drained();
      push_pixel(rand_pixel(), fs);
    end
  endtask

  // Default 640-wide image: two rows and a few pixels give the first medians
  task automatic test_reset_size();
    send_span(2 * eff_width(width_reg) + 4, 1'b1, 0, -1);
  endtask

  // Smallest images, clamped low register values, extreme pixels, frame wrap
  task automatic test_tiny_frames();
    logic [PIX_W-1:0] corner_px [6];
    corner_px = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
    set_size(11'd0, 11'd0);
    for (int i = 0; i < 6; i++) push_pixel(corner_px[i], i == 0);
    send_span(6, 1'b0, 0, -1);
    set_size(11'd1, 11'd2);
    send_span(6, 1'b1, 0, -1);
    set_size(11'd3, 11'd3);
    send_span(9, 1'b1, 0, -1);
  endtask

  // Sizes shrunk under a partly sent frame, then a restart in mid-frame
  task automatic test_size_shrink_midframe();
    set_size(11'd8, 11'd6);
    send_span(8 * 3 + 5, 1'b1, 0, -1);
    // column counter now past the new width: taken as the last column
    write_reg(mf3_pkg::CFG_IMAGE_WIDTH, 11'd4);
    send_span(3, 1'b0, 0, -1);
    // row counter now past the new height: taken as the last row
    write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, 11'd3);
    send_span(2, 1'b0, 0, -1);
    send_span(6, 1'b0, 0, -1);
    send_span(12, 1'b1, 0, -1);
  endtask

  // Upper register values: over-range sizes taken, a short stretch of row 0
  task automatic test_large_sizes();
    set_size(11'd2047, 11'd2047);
    send_span(40, 1'b1, 0, -1);
  endtask

  // Random sizes and whole frames with random content and some stray frame starts
  task automatic test_random_streams();
    int sent;
    int roll;
    int n;
    int frames;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        w = CFG_W'($urandom_range(2, 10));
        h = CFG_W'($urandom_range(3, 8));
      end else if (roll < 85) begin
        w = CFG_W'($urandom_range(11, 48));
        h = CFG_W'($urandom_range(3, 6));
      end else if (roll < 92) begin
        w = CFG_W'($urandom_range(49, 120));
        h = 11'd3;
      end else begin
        w = CFG_W'($urandom_range(0, 1));
        h = CFG_W'($urandom_range(0, 2));
      end
      set_size(w, h);
      steady = ($urandom_range(3) == 0);
      n = eff_width(w) * eff_height(h);
      frames = (n > 120) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        // a width change needs a frame start first; later frames may wrap
        send_span(n, (f == 0) ? 1'b1 : 1'($urandom_range(1)), 5,
                  ($urandom_range(2) == 0) ? int'($urandom_range(n - 1)) : -1);
        sent += n;
      end
      steady = 1'b0;
    end
  endtask

  // Main sequence
  initial begin
    rst_n              = 1'b0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_value = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = mf3_pkg::CFG_IMAGE_WIDTH;
    cfg_ch.data        = '0;
    mismatches         = 0;
    steady             = 1'b0;
    width_reg          = 11'd640;
    height_reg         = 11'd480;
    col_pos            = 0;
    row_pos            = 0;
    hist_max           = '{default: '0};
    hist_med           = '{default: '0};
    hist_min           = '{default: '0};
    for (int i = 0; i < MAX_WIDTH; i++) begin
      up_line[i]  = '0;
      mid_line[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_size();
    test_tiny_frames();
    test_size_shrink_midframe();
    test_large_sizes();
    test_random_streams();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_medians.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/mf3_pkg.sv
rtl/core/mf3_if.sv
rtl/core/mf3_line_store.sv
rtl/core/mf3_col_cell.sv
rtl/core/median_filter_3x3_top.sv
rtl/core/mf3_checker.sv
verif/tb_median_filter_3x3_top.sv
